// ----- rtl/sljc_pkg.sv -----
// shared types and constants for the sync/length/sum frame checker
// no dependencies; imported by every module of the block
package sljc_pkg;

  localparam int FRAME_BYTES_MAX_DEF = 4096;

  localparam int HDR_BYTES = 6;

  // configuration register indexes
  localparam logic [1:0] REG_SYNC_WORD = 2'd0;
  localparam logic [1:0] REG_EXP_TYPE  = 2'd1;
  localparam logic [1:0] REG_EXP_ID    = 2'd2;

  localparam logic [15:0] SYNC_WORD_RST = 16'h55AA;
  localparam logic [7:0]  EXP_TYPE_RST  = 8'h01;
  localparam logic [7:0]  EXP_ID_RST    = 8'h95;

  // frame status codes
  localparam logic [1:0] STAT_PEND = 2'd0;
  localparam logic [1:0] STAT_OK   = 2'd1;
  localparam logic [1:0] STAT_BAD  = 2'd2;

  // held header bytes after alignment
  typedef struct packed {
    logic [HDR_BYTES-1:0][7:0] bytes;
    logic [2:0]                cnt;
  } hdr_t;

endpackage

// ----- rtl/sljc_hdr_align.sv -----
// header byte alignment: appends a byte and realigns on the earliest valid sync start
// depends on sljc_pkg
module sljc_hdr_align import sljc_pkg::*; #(
  parameter int FrameBytesMax = FRAME_BYTES_MAX_DEF
) (
  input  logic [HDR_BYTES-1:0][7:0] held_i,
  input  logic [2:0]                cnt_i,
  input  logic [7:0]                rx_i,
  input  logic [15:0]               sync_i,
  input  logic [7:0]                type_i,
  input  logic [7:0]                id_i,
  output hdr_t                      hdr_o
);

  localparam logic [17:0] MaxL = 18'(FrameBytesMax);

  logic [HDR_BYTES-1:0][7:0] w;
  logic [2:0]  n_in;
  logic [2:0]  n;
  logic [HDR_BYTES-1:0] ok;
  logic [2:0]  sel;
  logic [15:0] len;
  logic        len_ok;

  function automatic logic [7:0] at(input logic [HDR_BYTES-1:0][7:0] v, input int k);
    logic [7:0] r;
    r = 8'h00;
    if (k < HDR_BYTES) r = v[k[2:0]];
    return r;
  endfunction

  assign n_in = (cnt_i > 3'd5) ? 3'd0 : cnt_i;
  assign n    = n_in + 3'd1;

  always_comb begin
    w       = held_i;
    w[n_in] = rx_i;
  end

  assign len    = {w[5], w[4]};
  assign len_ok = (len >= 16'd4) && (({2'b00, len} + 18'd2) <= MaxL);

  // ok[p]: the held bytes from p on form a valid header prefix
  always_comb begin
    ok = '1;
    for (int p = 0; p < HDR_BYTES; p++) begin
      if (int'(n) > p)     ok[p] = ok[p] && (at(w, p)     == sync_i[7:0]);
      if (int'(n) > p + 1) ok[p] = ok[p] && (at(w, p + 1) == sync_i[15:8]);
      if (int'(n) > p + 2) ok[p] = ok[p] && (at(w, p + 2) == type_i);
      if (int'(n) > p + 3) ok[p] = ok[p] && (at(w, p + 3) == id_i);
    end
    if (n == 3'd6) ok[0] = ok[0] && len_ok;
  end

  // earliest passing start; none means drop everything
  always_comb begin
    sel = 3'd6;
    for (int p = HDR_BYTES - 1; p >= 0; p--) begin
      if (ok[p]) sel = 3'(p);
    end
  end

  always_comb begin
    for (int k = 0; k < HDR_BYTES; k++) begin
      hdr_o.bytes[k] = at(w, int'(sel) + k);
    end
    hdr_o.cnt = n - sel;
  end

endmodule

// ----- rtl/sync_length_sum_frame_checker_core.sv -----
// channel  | handshake                 | payload
// rx       | rx_valid_i / rx_ready_o   | rx_byte_i
// out      | out_valid_o / out_ready_i | out_byte_o, byte_offset_o, frame_last_o, frame_status_o
// cfg      | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
// one byte per cycle unless stalled: each accepted byte updates the frame state in the same cycle
// and any result lands in the output register the next cycle
// rx_ready_o drops only while a result waits in the output register unaccepted
// asynchronous active-low reset clears phase, counters, sum and config to defaults
// depends on sljc_pkg and sljc_hdr_align
module sync_length_sum_frame_checker_core import sljc_pkg::*; #(
  parameter int FrameBytesMax = FRAME_BYTES_MAX_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic [12:0] byte_offset_o,
  output logic        frame_last_o,
  output logic [1:0]  frame_status_o
);

  localparam int CntL = $clog2(FrameBytesMax);
  localparam int CntW = (CntL > 13) ? CntL : 13;
  localparam int CmpW = (CntW > 16) ? CntW : 16;

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_HDR  = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;

  logic [15:0] sync_q;
  logic [7:0]  type_q, id_q;

  logic [1:0]                phase_q, phase_d;
  logic [HDR_BYTES-1:0][7:0] held_q, held_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic [15:0]               len_q, len_d;
  logic [15:0]               sum_q, sum_d;
  logic [7:0]                cklo_q, cklo_d;

  logic        ov_q;
  logic [7:0]  ob_q, ob_d;
  logic [12:0] ooff_q, ooff_d;
  logic        olast_q, olast_d;
  logic [1:0]  ost_q, ost_d;
  logic        res_v;

  logic        rx_acc;
  hdr_t        hdr;
  logic [15:0] hlen, hsum;
  logic [CmpW-1:0] cnt_x, len_x;

  assign rx_ready_o = !ov_q || out_ready_i;
  assign rx_acc     = rx_valid_i && rx_ready_o;

  sljc_hdr_align #(.FrameBytesMax(FrameBytesMax)) u_align (
    .held_i (held_q),
    .cnt_i  (cnt_q[2:0]),
    .rx_i   (rx_byte_i),
    .sync_i (sync_q),
    .type_i (type_q),
    .id_i   (id_q),
    .hdr_o  (hdr)
  );

  assign hlen  = {hdr.bytes[5], hdr.bytes[4]};
  assign hsum  = 16'(hdr.bytes[2]) + 16'(hdr.bytes[3]);
  assign cnt_x = CmpW'(cnt_q);
  assign len_x = CmpW'(len_q);

  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    cnt_d   = cnt_q;
    len_d   = len_q;
    sum_d   = sum_q;
    cklo_d  = cklo_q;
    res_v   = 1'b0;
    ob_d    = 8'h00;
    ooff_d  = cnt_q[12:0];
    olast_d = 1'b0;
    ost_d   = STAT_PEND;
    if (phase_q == PH_BODY) begin
      if (cnt_x < len_x) begin
        sum_d = sum_q + 16'(rx_byte_i);
        cnt_d = cnt_q + CntW'(1);
        res_v = 1'b1;
        ob_d  = rx_byte_i;
      end else if (cnt_x == len_x) begin
        // checksum low byte, no result
        cklo_d = rx_byte_i;
        cnt_d  = cnt_q + CntW'(1);
      end else begin
        res_v   = 1'b1;
        olast_d = 1'b1;
        ost_d   = ({rx_byte_i, cklo_q} == sum_q) ? STAT_OK : STAT_BAD;
        phase_d = PH_HUNT;
        cnt_d   = '0;
        sum_d   = '0;
      end
    end else begin
      held_d = hdr.bytes;
      if (hdr.cnt == 3'd6) begin
        len_d = hlen;
        if (hlen == 16'd4) begin
          // the length field doubles as the checksum
          res_v   = 1'b1;
          ooff_d  = 13'd5;
          olast_d = 1'b1;
          ost_d   = (hsum == hlen) ? STAT_OK : STAT_BAD;
          phase_d = PH_HUNT;
          cnt_d   = '0;
          sum_d   = '0;
        end else begin
          if (hlen == 16'd5) begin
            cklo_d = hdr.bytes[5];
            sum_d  = hsum + 16'(hdr.bytes[4]);
          end else begin
            sum_d  = hsum + 16'(hdr.bytes[4]) + 16'(hdr.bytes[5]);
          end
          cnt_d   = CntW'(6);
          phase_d = PH_BODY;
        end
      end else begin
        cnt_d   = CntW'(hdr.cnt);
        phase_d = (hdr.cnt >= 3'd2) ? PH_HDR : PH_HUNT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q <= SYNC_WORD_RST;
      type_q <= EXP_TYPE_RST;
      id_q   <= EXP_ID_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SYNC_WORD: sync_q <= cfg_wdata_i;
        REG_EXP_TYPE:  type_q <= cfg_wdata_i[7:0];
        REG_EXP_ID:    id_q   <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      held_q  <= '0;
      cnt_q   <= '0;
      len_q   <= '0;
      sum_q   <= '0;
      cklo_q  <= '0;
    end else if (rx_acc) begin
      phase_q <= phase_d;
      held_q  <= held_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      sum_q   <= sum_d;
      cklo_q  <= cklo_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (rx_ready_o) begin
      ov_q <= rx_acc && res_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_acc && res_v) begin
      ob_q    <= ob_d;
      ooff_q  <= ooff_d;
      olast_q <= olast_d;
      ost_q   <= ost_d;
    end
  end

  assign out_valid_o    = ov_q;
  assign out_byte_o     = ob_q;
  assign byte_offset_o  = ooff_q;
  assign frame_last_o   = olast_q;
  assign frame_status_o = ost_q;

endmodule

// ----- rtl/sljc_checker.sv -----
// port-level assertions for the frame checker core, attached by bind
// depends on sljc_pkg
module sljc_checker import sljc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        rx_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  out_byte_o,
  input logic [12:0] byte_offset_o,
  input logic        frame_last_o,
  input logic [1:0]  frame_status_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(byte_offset_o) && $stable(frame_last_o) && $stable(frame_status_o))
    else $error("stalled result changed");

  // input is only held off by a waiting result
  a_rx_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o || out_ready_i |-> rx_ready_o)
    else $error("input stalled without a waiting result");

  // status item carries a final status and no data
  a_last_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_last_o |-> out_byte_o == 8'h00
      && (frame_status_o == STAT_OK || frame_status_o == STAT_BAD))
    else $error("bad status item");

  // payload items stay pending and sit past the header
  a_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_last_o |-> frame_status_o == STAT_PEND && byte_offset_o >= 13'd6)
    else $error("bad payload item");

  // the status item never comes before the header ends
  a_last_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_last_o |-> byte_offset_o >= 13'd5)
    else $error("status offset inside header");

endmodule

bind sync_length_sum_frame_checker_core sljc_checker u_sljc_checker (.*);

// ----- verif/tb_sync_length_sum_frame_checker_core.sv -----
// self-checking testbench for sync_length_sum_frame_checker_core: framed byte stream in,
// payload bytes and frame status out, checked against a scoreboard that tracks the header scan
// depends on sljc_pkg and the rtl of the core
module tb_sync_length_sum_frame_checker_core;
  import sljc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned PHASE_ITEMS = 200;

  typedef enum logic [1:0] {PH_HUNT, PH_HDR, PH_BODY} scan_phase_e;

  typedef struct packed {
    logic [7:0]  data;
    logic [12:0] offset;
    logic        last;
    logic [1:0]  status;
  } frame_res_t;

  class frame_scoreboard;
    logic [7:0]  sync_lo, sync_hi, exp_type, exp_id;
    scan_phase_e ph;
    logic [7:0]  held [6];
    int unsigned cnt;
    int unsigned flen;
    logic [15:0] sum;
    logic [7:0]  cks_lo;
    frame_res_t  want_q [$];
    int unsigned errors;

    function new();
      sync_lo  = SYNC_WORD_RST[7:0];
      sync_hi  = SYNC_WORD_RST[15:8];
      exp_type = EXP_TYPE_RST;
      exp_id   = EXP_ID_RST;
      ph       = PH_HUNT;
      foreach (held[i]) held[i] = 8'h00;
      cnt      = 0;
      flen     = 0;
      sum      = 16'h0000;
      cks_lo   = 8'h00;
      errors   = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        REG_SYNC_WORD: begin
          sync_lo = val[7:0];
          sync_hi = val[15:8];
        end
        REG_EXP_TYPE: exp_type = val[7:0];
        REG_EXP_ID:   exp_id = val[7:0];
        default: ;
      endcase
    endfunction

    function bit idle();
      return ph != PH_BODY && cnt == 0;
    endfunction

    function int unsigned pending();
      return want_q.size();
    endfunction

    function void push_result(logic [7:0] d, int unsigned off, logic lst, logic [1:0] st);
      frame_res_t r;
      r.data   = d;
      r.offset = 13'(off);
      r.last   = lst;
      r.status = st;
      want_q.push_back(r);
    endfunction

    function bit header_ok();
      int unsigned len;
      if (cnt >= 1 && held[0] != sync_lo) return 1'b0;
      if (cnt >= 2 && held[1] != sync_hi) return 1'b0;
      if (cnt >= 3 && held[2] != exp_type) return 1'b0;
      if (cnt >= 4 && held[3] != exp_id) return 1'b0;
      if (cnt >= 6) begin
        len = 32'({held[5], held[4]});
        if (len < 4 || len + 2 > FRAME_BYTES_MAX_DEF) return 1'b0;
      end
      return 1'b1;
    endfunction

    // drop the first held byte and slide down to the next sync pair or trailing sync low
    function void realign();
      int unsigned n;
      bit hit;
      n = cnt;
      for (int unsigned p = 1; p < n && p < 6; p++) begin
        hit = 1'b0;
        if (held[p] == sync_lo) begin
          if (p + 1 == n) hit = 1'b1;
          else if (held[p+1] == sync_hi) hit = 1'b1;
        end
        if (hit) begin
          for (int unsigned k = 0; k < n - p; k++) held[k] = held[k+p];
          cnt = n - p;
          return;
        end
      end
      cnt = 0;
    endfunction

    function void note_byte(logic [7:0] rx);
      int unsigned len;
      logic [15:0] s;
      if (ph == PH_BODY) begin
        if (cnt < flen) begin
          sum = sum + 16'(rx);
          push_result(rx, cnt, 1'b0, STAT_PEND);
          cnt++;
        end else if (cnt == flen) begin
          cks_lo = rx;
          cnt++;
        end else begin
          push_result(8'h00, cnt, 1'b1, ({rx, cks_lo} == sum) ? STAT_OK : STAT_BAD);
          ph  = PH_HUNT;
          cnt = 0;
          sum = 16'h0000;
        end
        return;
      end
      if (cnt > 5) cnt = 0;
      held[cnt] = rx;
      cnt++;
      while (!header_ok()) realign();
      if (cnt == 6) begin
        len  = 32'({held[5], held[4]});
        s    = 16'(held[2]) + 16'(held[3]);
        flen = len;
        // length 4: the length field doubles as the checksum
        if (len == 4) begin
          push_result(8'h00, 5, 1'b1, (s == 16'd4) ? STAT_OK : STAT_BAD);
          ph  = PH_HUNT;
          cnt = 0;
          sum = 16'h0000;
          return;
        end
        s = s + 16'(held[4]);
        if (len == 5) cks_lo = held[5];
        else s = s + 16'(held[5]);
        sum = s;
        ph  = PH_BODY;
        return;
      end
      ph = (cnt >= 2) ? PH_HDR : PH_HUNT;
    endfunction

    function void check(frame_res_t got);
      frame_res_t want;
      if (want_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: byte %02h offset %0d last %0b status %0d",
                   got.data, got.offset, got.last, got.status);
        return;
      end
      want = want_q.pop_front();
      if (got.data !== want.data || got.offset !== want.offset ||
          got.last !== want.last || got.status !== want.status) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: expected byte %02h offset %0d last %0b status %0d",
                   want.data, want.offset, want.last, want.status);
          $display("          got      byte %02h offset %0d last %0b status %0d",
                   got.data, got.offset, got.last, got.status);
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_wdata_i;
  logic        rx_valid_i;
  logic        rx_ready_o;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  out_byte_o;
  logic [12:0] byte_offset_o;
  logic        frame_last_o;
  logic [1:0]  frame_status_o;

  frame_scoreboard sb;
  logic [7:0]      frame_q [$];
  int unsigned     items_sent;
  int unsigned     cycles;
  bit              rx_burst;
  bit              out_burst;

  sync_length_sum_frame_checker_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .rx_valid_i     (rx_valid_i),
    .rx_ready_o     (rx_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .byte_offset_o  (byte_offset_o),
    .frame_last_o   (frame_last_o),
    .frame_status_o (frame_status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles = cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    frame_res_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.data   = out_byte_o;
      got.offset = byte_offset_o;
      got.last   = frame_last_o;
      got.status = frame_status_o;
      sb.check(got);
    end
  end

  // result side: random stall before each result, with stall-free stretches
  initial begin
    int unsigned stall;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
      stall = out_burst ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // returns in the step the item is accepted, with valid still high
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
    gap = rx_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      rx_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!rx_ready_o);
    sb.note_byte(b);
    items_sent++;
  endtask

  task automatic send_queue(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_byte(frame_q[i]);
  endtask

  // whole frame for the current config; a bad checksum corrupts the last byte when the length is 5 or more
  task automatic build_frame(input int unsigned len, input bit good);
    logic [15:0] s;
    frame_q.delete();
    frame_q.push_back(sb.sync_lo);
    frame_q.push_back(sb.sync_hi);
    frame_q.push_back(sb.exp_type);
    frame_q.push_back(sb.exp_id);
    frame_q.push_back(8'(len));
    frame_q.push_back(8'(len >> 8));
    for (int unsigned i = 6; i < len; i++) frame_q.push_back(8'($urandom));
    s = 16'h0000;
    for (int unsigned i = 2; i < len; i++) s = s + 16'(frame_q[i]);
    if (len >= 6) begin
      frame_q.push_back(s[7:0]);
      frame_q.push_back(s[15:8]);
    end else if (len == 5) begin
      frame_q.push_back(s[15:8]);
    end
    if (!good && len >= 5) frame_q[frame_q.size()-1] ^= 8'($urandom_range(1, 255));
  endtask

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(4, 7);
    if (r < 95) return $urandom_range(8, 40);
    return $urandom_range(41, 300);
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 3))
      0: return sb.sync_lo;
      1: return sb.sync_hi;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic random_phase(input int unsigned n);
    int unsigned start, kind, len;
    start = items_sent;
    while (items_sent - start < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        build_frame(pick_len(), $urandom_range(0, 3) != 0);
        send_queue(frame_q.size());
      end else if (kind < 70) begin
        // broken sync, type or id byte
        build_frame(pick_len(), 1'b1);
        frame_q[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
        send_queue(frame_q.size());
      end else if (kind < 78) begin
        // header with a length too short or too long
        build_frame(4, 1'b1);
        len = $urandom_range(0, 1) ? $urandom_range(0, 3)
                                   : $urandom_range(FRAME_BYTES_MAX_DEF - 1, 65535);
        frame_q[4] = 8'(len);
        frame_q[5] = 8'(len >> 8);
        send_queue(6);
      end else if (kind < 88) begin
        build_frame(pick_len(), 1'b1);
        send_queue($urandom_range(1, frame_q.size() - 1));
      end else begin
        repeat ($urandom_range(1, 8)) send_byte(noise_byte());
      end
    end
  endtask

  // push the block back to hunting with nothing held, then let it drain
  task automatic settle();
    logic [7:0] x;
    do x = 8'($urandom_range(16, 255));
    while (x == sb.sync_lo || x == sb.sync_hi || x == sb.exp_type || x == sb.exp_id);
    while (!sb.idle()) send_byte(x);
    rx_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [15:0] sw, input logic [7:0] ty, input logic [7:0] id);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_SYNC_WORD;
    cfg_wdata_i <= sw;
    @(posedge clk_i);
    sb.set_reg(REG_SYNC_WORD, sw);
    cfg_idx_i   <= REG_EXP_TYPE;
    cfg_wdata_i <= {8'($urandom), ty};
    @(posedge clk_i);
    sb.set_reg(REG_EXP_TYPE, {8'h00, ty});
    cfg_idx_i   <= REG_EXP_ID;
    cfg_wdata_i <= {8'($urandom), id};
    @(posedge clk_i);
    sb.set_reg(REG_EXP_ID, {8'h00, id});
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    logic [7:0] rep;
    sb          = new();
    items_sent  = 0;
    cycles      = 0;
    rx_burst    = 1'b0;
    out_burst   = 1'b0;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= REG_SYNC_WORD;
    cfg_wdata_i <= 16'h0000;
    rx_valid_i  <= 1'b0;
    rx_byte_i   <= 8'h00;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset config
    send_byte(8'h00);
    send_byte(8'hFF);
    // doubled sync low byte forces a rescan ahead of a length-4 frame
    send_byte(sb.sync_lo);
    build_frame(4, 1'b1);
    send_queue(6);
    build_frame(5, 1'b1);
    send_queue(7);
    build_frame(7, 1'b1);
    send_queue(9);
    random_phase(PHASE_ITEMS);

    for (int k = 1; k < 5; k++) begin
      settle();
      case (k)
        1: write_config(16'h0000, 8'h00, 8'h04);  // type + id = 4 lets a length-4 frame pass
        2: write_config(16'hFFFF, 8'hFF, 8'hFF);
        3: begin
          rep = 8'($urandom);
          write_config({rep, rep}, 8'($urandom), 8'($urandom));
        end
        default: write_config(16'($urandom), 8'($urandom), 8'($urandom));
      endcase
      random_phase(PHASE_ITEMS);
    end

    rx_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/sljc_pkg.sv
rtl/sljc_hdr_align.sv
rtl/sync_length_sum_frame_checker_core.sv
rtl/sljc_checker.sv
verif/tb_sync_length_sum_frame_checker_core.sv
